/* sv/gkde_pkg.sv */
// ----------------------------------------------------------------------------
// gkde_pkg
// shared constants, codes and exp table builder for the kde grid evaluator
// ----------------------------------------------------------------------------
package gkde_pkg;

    localparam int unsigned MAX_SAMPLES_DEF     = 1024;
    localparam int unsigned GRID_W_MAX_DEF      = 1024;
    localparam int unsigned GRID_H_MAX_DEF      = 1024;
    localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

    // exponent argument limit: 16.0 in q16.16
    localparam int unsigned ARG_W     = 21;
    localparam logic [ARG_W-1:0] ARG_LIMIT = 21'h100000;
    localparam int unsigned TERM_W    = 17;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_X_ORIGIN = 3'd0,
        REG_X_STEP   = 3'd1,
        REG_Y_ORIGIN = 3'd2,
        REG_Y_STEP   = 3'd3,
        REG_KX       = 3'd4,
        REG_KY       = 3'd5,
        REG_NORM     = 3'd6,
        REG_UNUSED   = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR,
        ST_CEN,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_DONE
    } state_t;

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // entry idx of exp(-16 i / depth) in q16.16
    function automatic logic [31:0] exp_entry(input int unsigned idx, input int unsigned depth);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r32;
        logic [63:0] cur;
        logic [63:0] res;
        term = 64'd1 << 59;
        sum  = 64'd1 << 59;
        res  = '0;
        for (int unsigned k = 1; k <= 24; k++) begin
            term = udiv64(term * 64'd16, 64'(depth) * 64'(k));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r32 = (sum + (64'd1 << 26)) >> 27;
        cur = 64'd1 << 32;
        for (int unsigned i = 0; i <= idx; i++) begin
            res = (cur + 64'h8000) >> 16;
            cur = (cur * r32 + 64'h8000_0000) >> 32;
        end
        return res[31:0];
    endfunction

endpackage

/* sv/gkde_sample_mem.sv */
// ----------------------------------------------------------------------------
// gkde_sample_mem
// sample point store, one write port and one registered read port
// ----------------------------------------------------------------------------
module gkde_sample_mem
    import gkde_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_SAMPLES_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/gkde_axis.sv */
// ----------------------------------------------------------------------------
// gkde_axis
// four stage exponent argument for one axis: floor(d^2 * k) in q16.16
// ----------------------------------------------------------------------------
module gkde_axis
    import gkde_pkg::*;
(
    input  logic               clk,
    input  logic signed [42:0] center,
    input  logic signed [31:0] coord,
    input  logic [31:0]        k,
    output logic [ARG_W-1:0]   arg
);

    logic signed [43:0] diff;
    logic [43:0]        mag;

    logic [31:0] ad_reg;
    logic        oor1_reg;
    logic [63:0] sq_reg;
    logic        oor2_reg;
    logic [63:0] phi_reg;
    logic [63:0] plo_reg;
    logic        oor3_reg;
    logic [64:0] r;
    logic [ARG_W-1:0] arg_reg;
    logic [ARG_W-1:0] arg_next;

    assign diff = 44'(center) - 44'(coord);
    assign mag  = diff[43] ? 44'(-diff) : 44'(diff);

    always_ff @(posedge clk)
    begin
        ad_reg   <= mag[31:0];
        oor1_reg <= (mag[43:32] != '0);
        sq_reg   <= 64'(ad_reg) * 64'(ad_reg);
        oor2_reg <= oor1_reg;
        phi_reg  <= 64'(sq_reg[63:32]) * 64'(k);
        plo_reg  <= 64'(sq_reg[31:0]) * 64'(k);
        oor3_reg <= oor2_reg;
        arg_reg  <= arg_next;
    end

    assign r = 65'(phi_reg) + 65'(plo_reg[63:32]);

    always_comb
    begin
        if (k == '0)
            arg_next = '0;
        else if (oor3_reg || (r >= 65'(ARG_LIMIT)))
            arg_next = ARG_LIMIT;
        else
            arg_next = r[ARG_W-1:0];
    end

    assign arg = arg_reg;

endmodule

/* sv/gkde_kernel.sv */
// ----------------------------------------------------------------------------
// gkde_kernel
// per-sample kernel term: both axis arguments, table index, exp table lookup
// ----------------------------------------------------------------------------
module gkde_kernel
    import gkde_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic signed [42:0] gx,
    input  logic signed [42:0] gy,
    input  logic [63:0]        sample,
    input  logic [31:0]        kx,
    input  logic [31:0]        ky,
    output logic [TERM_W-1:0]  term
);

    localparam int unsigned IW = $clog2(EXP_TABLE_DEPTH);

    logic [ARG_W-1:0]    ex;
    logic [ARG_W-1:0]    ey;
    logic [ARG_W:0]      esum;
    logic                skip;
    logic [ARG_W+12:0]   scaled;
    logic [IW-1:0]       idx_reg;
    logic                skip_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [TERM_W-1:0]   exp_rom [EXP_TABLE_DEPTH];

    for (genvar i = 0; i < EXP_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [31:0] ENTRY = exp_entry(i, EXP_TABLE_DEPTH);
        assign exp_rom[i] = ENTRY[TERM_W-1:0];
    end

    gkde_axis u_axis_x (
        .clk    (clk),
        .center (gx),
        .coord  (sample[31:0]),
        .k      (kx),
        .arg    (ex)
    );

    gkde_axis u_axis_y (
        .clk    (clk),
        .center (gy),
        .coord  (sample[63:32]),
        .k      (ky),
        .arg    (ey)
    );

    assign esum   = {1'b0, ex} + {1'b0, ey};
    assign skip   = (ex == ARG_LIMIT) || (ey == ARG_LIMIT) || (esum >= {1'b0, ARG_LIMIT});
    assign scaled = (ARG_W+13)'(esum[ARG_W-1:0]) * (ARG_W+13)'(EXP_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        idx_reg  <= scaled[IW+19:20];
        skip_reg <= skip;
        term_reg <= skip_reg ? '0 : exp_rom[idx_reg];
    end

    assign term = term_reg;

endmodule

/* sv/gaussian_kde_grid_eval_core.sv */
// ----------------------------------------------------------------------------
// gaussian_kde_grid_eval_core
// two-dimensional gaussian kernel density at one grid cell, q16.16
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one request: opcode, sample_x,
//   sample_y, cell_col, cell_row. clear and append return nothing. an
//   evaluate request returns one result on the output channel
//   (out_valid / out_stall): density, saturated, store_full.
//   config port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   seven registers; it is always ready and is meant for idle periods.
// evaluate flow
//   evaluate runs from acceptance to result through the cell center states
//   (ST_CTR, ST_CEN), one store read per cycle over count samples, the
//   kernel pipeline drain after the last read, one scale multiply and one
//   output load.
//   the single read port of the sample store sets the one sample per cycle.
//   while an evaluate is in flight the input side is stalled.
// reset
//   registers return to their documented values and the sample count to zero;
//   store contents are left as they are and only written entries are read.
// output stall
//   the result sits in an output register; a new request can be taken while
//   it waits, and a following evaluate holds in its last state until the
//   output register is free.
// ----------------------------------------------------------------------------
module gaussian_kde_grid_eval_core
    import gkde_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES     = MAX_SAMPLES_DEF,
    parameter int unsigned GRID_W_MAX      = GRID_W_MAX_DEF,
    parameter int unsigned GRID_H_MAX      = GRID_H_MAX_DEF,
    parameter int unsigned EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] sample_x,
    input  logic signed [31:0] sample_y,
    input  logic [9:0]         cell_col,
    input  logic [9:0]         cell_row,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        density,
    output logic               saturated,
    output logic               store_full,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned ACCW = TERM_W + CW;
    localparam int unsigned PIPE = 7;

    // configuration registers
    logic [31:0] x_origin_reg;
    logic [30:0] x_step_reg;
    logic [31:0] y_origin_reg;
    logic [30:0] y_step_reg;
    logic [31:0] kx_reg;
    logic [31:0] ky_reg;
    logic [31:0] norm_reg;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      rd_ptr_reg;
    logic [9:0]         col_reg;
    logic [9:0]         row_reg;
    logic [41:0]        offx_reg;
    logic [41:0]        offy_reg;
    logic signed [42:0] gx_reg;
    logic signed [42:0] gy_reg;
    logic [PIPE-1:0]    vld_reg;
    logic [ACCW-1:0]    acc_reg;
    logic [63:0]        prod_reg;
    logic               out_valid_reg;
    logic [31:0]        density_reg;
    logic               saturated_reg;
    logic               full_reg;

    logic               in_acc;
    logic               mem_we;
    logic               issue;
    logic [63:0]        rdata;
    logic [TERM_W-1:0]  term;
    logic [63:0]        acc_wide;
    logic [31:0]        acc_clamp;
    logic [47:0]        dens_wide;
    logic               out_free;
    logic               load_out;
    logic [9:0]         col_clamp;
    logic [9:0]         row_clamp;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign mem_we    = in_acc && (opcode == OP_APPEND) && (count_reg < CW'(MAX_SAMPLES));
    assign issue     = (state_reg == ST_RUN) && (rd_ptr_reg < count_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_DONE) && out_free;

    // out-of-grid indexes saturate to the last column / row
    assign col_clamp = (13'(cell_col) > 13'(GRID_W_MAX - 1)) ? 10'(GRID_W_MAX - 1) : cell_col;
    assign row_clamp = (13'(cell_row) > 13'(GRID_H_MAX - 1)) ? 10'(GRID_H_MAX - 1) : cell_row;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            x_step_reg   <= 31'd65536;
            y_origin_reg <= '0;
            y_step_reg   <= 31'd65536;
            kx_reg       <= 32'd32768;
            ky_reg       <= 32'd32768;
            norm_reg     <= 32'd10430;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_X_STEP:   x_step_reg   <= cfg_data[30:0];
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_Y_STEP:   y_step_reg   <= cfg_data[30:0];
                REG_KX:       kx_reg       <= cfg_data;
                REG_KY:       ky_reg       <= cfg_data;
                REG_NORM:     norm_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc && (opcode == OP_EVAL)) state_next = ST_CTR;
            ST_CTR:   state_next = ST_CEN;
            ST_CEN:   state_next = ST_RUN;
            ST_RUN:   if (!issue) state_next = ST_DRAIN;
            ST_DRAIN: if (vld_reg == '0) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= {vld_reg[PIPE-2:0], issue};
            if (in_acc && (opcode == OP_CLEAR))
                count_reg <= '0;
            else if (mem_we)
                count_reg <= count_reg + 1'b1;
            if (state_reg == ST_CEN)
                rd_ptr_reg <= '0;
            else if (issue)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // cell center: origin + ((2 idx + 1) * step) / 2
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            col_reg <= col_clamp;
            row_reg <= row_clamp;
        end
        offx_reg <= 42'({col_reg, 1'b1}) * 42'(x_step_reg);
        offy_reg <= 42'({row_reg, 1'b1}) * 42'(y_step_reg);
        gx_reg   <= $signed({{11{x_origin_reg[31]}}, x_origin_reg})
                    + $signed({2'b00, offx_reg[41:1]});
        gy_reg   <= $signed({{11{y_origin_reg[31]}}, y_origin_reg})
                    + $signed({2'b00, offy_reg[41:1]});
    end

    // term accumulation, then scaling by norm
    assign acc_wide  = 64'(acc_reg);
    assign acc_clamp = (acc_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_wide[31:0];
    assign dens_wide = prod_reg[63:16];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CEN)
            acc_reg <= '0;
        else if (vld_reg[PIPE-1])
            acc_reg <= acc_reg + ACCW'(term);
        prod_reg <= 64'(acc_clamp) * 64'(norm_reg);
        if (load_out)
        begin
            density_reg   <= (dens_wide[47:32] != '0) ? 32'hFFFF_FFFF : dens_wide[31:0];
            saturated_reg <= (dens_wide[47:32] != '0);
            full_reg      <= (count_reg >= CW'(MAX_SAMPLES));
        end
    end

    assign out_valid  = out_valid_reg;
    assign density    = density_reg;
    assign saturated  = saturated_reg;
    assign store_full = full_reg;

    gkde_sample_mem #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({sample_y, sample_x}),
        .re    (issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    gkde_kernel #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_kernel (
        .clk    (clk),
        .gx     (gx_reg),
        .gy     (gy_reg),
        .sample (rdata),
        .kx     (kx_reg),
        .ky     (ky_reg),
        .term   (term)
    );

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !mem_we)
        else $error("store write during evaluate sweep");

    a_term_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE-1] |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("kernel term outside of evaluate");

    a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (vld_reg == '0))
        else $error("scale before kernel pipeline drained");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the kde grid evaluator: a clocked driver and
// monitor around an in-bench density predictor, directed corner requests,
// randomized clear/append/evaluate sequences over several register settings
// ----------------------------------------------------------------------------
module tb_top;
    import gkde_pkg::*;

    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned TBL_DEPTH   = 256;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam logic [63:0] ARG_TOP     = 64'd16 << 16;

    typedef struct {
        opcode_t     op;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [9:0]  col;
        logic [9:0]  row;
    } kde_req_t;

    typedef struct {
        logic [31:0] dens;
        logic        sat;
        logic        full;
    } kde_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [31:0] sample_x;
    logic [31:0] sample_y;
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] density;
    logic        saturated;
    logic        store_full;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // pending requests filled by the sequencer, popped by the driver
    kde_req_t req_fifo[$];
    // densities the predictor expects, oldest first
    kde_res_t density_fifo[$];

    // predictor copy of registers and sample store
    logic [31:0] p_xo, p_yo, p_kx, p_ky, p_norm;
    logic [30:0] p_xs, p_ys;
    logic [31:0] mem_x[STORE_DEPTH];
    logic [31:0] mem_y[STORE_DEPTH];
    int unsigned p_count;
    logic [31:0] exp_lut[TBL_DEPTH];

    int  idle_mode;       // 0: sender 24 / receiver 87, 1: reversed, 2: no idling
    int  n_req, n_dens, n_sat, n_full, n_err;
    int  quiet_cycles;
    int  hold_cnt;
    bit  hold_done;

    gaussian_kde_grid_eval_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .density    (density),
        .saturated  (saturated),
        .store_full (store_full),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // exp(-16 i / depth) table in q16.16: step ratio from a truncated taylor
    // series in q5.59, then repeated rounded products in q0.32
    function automatic void build_exp_lut();
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] ratio;
        logic [63:0] cur;
        term = 64'd1 << 59;
        acc  = 64'd1 << 59;
        for (int k = 1; k <= 24; k++)
        begin
            term = (term * 64'd16) / (64'(TBL_DEPTH) * 64'(k));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        ratio = (acc + (64'd1 << 26)) >> 27;
        cur = 64'd1 << 32;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            exp_lut[i] = 32'((cur + 64'h8000) >> 16);
            cur = (cur * ratio + 64'h8000_0000) >> 32;
        end
    endfunction

    // q16.16 exponent contribution of one axis, clipped at 16.0
    function automatic logic [63:0] axis_exponent(input logic signed [63:0] d,
                                                  input logic [31:0] k);
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] r;
        if (k == 0)
            return 64'd0;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        if (mag > 64'hFFFF_FFFF)
            return ARG_TOP;
        sq = mag * mag;
        r  = (sq >> 32) * 64'(k) + (((sq & 64'hFFFF_FFFF) * 64'(k)) >> 32);
        return (r >= ARG_TOP) ? ARG_TOP : r;
    endfunction

    function automatic logic signed [63:0] cell_center(input logic [31:0] origin,
                                                       input logic [30:0] step,
                                                       input logic [9:0] idx);
        logic [63:0] off;
        off = ((64'd2 * 64'(idx) + 64'd1) * 64'(step)) >> 1;
        return 64'(signed'(origin)) + signed'(off);
    endfunction

    function automatic kde_res_t predict_density(input logic [9:0] col,
                                                 input logic [9:0] row);
        kde_res_t r;
        logic signed [63:0] gx, gy;
        logic [63:0] ex, ey, e, acc, d;
        gx  = cell_center(p_xo, p_xs, col);
        gy  = cell_center(p_yo, p_ys, row);
        acc = 0;
        for (int i = 0; i < p_count; i++)
        begin
            ex = axis_exponent(gx - 64'(signed'(mem_x[i])), p_kx);
            ey = axis_exponent(gy - 64'(signed'(mem_y[i])), p_ky);
            e  = ex + ey;
            if (ex < ARG_TOP && ey < ARG_TOP && e < ARG_TOP)
                acc = acc + 64'(exp_lut[(e * TBL_DEPTH) >> 20]);
        end
        if (acc > 64'hFFFF_FFFF)
            acc = 64'hFFFF_FFFF;
        d = (acc * 64'(p_norm)) >> 16;
        r.sat  = (d > 64'hFFFF_FFFF);
        r.dens = r.sat ? 32'hFFFF_FFFF : d[31:0];
        r.full = (p_count >= STORE_DEPTH);
        return r;
    endfunction

    // driver: hold the request while stalled, otherwise offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= OP_NONE;
            sample_x <= '0;
            sample_y <= '0;
            cell_col <= '0;
            cell_row <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (req_fifo.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 24) &&
                !(idle_mode == 1 && $urandom_range(99) < 87))
            begin
                kde_req_t q;
                q = req_fifo.pop_front();
                in_valid <= 1'b1;
                opcode   <= q.op;
                sample_x <= q.sx;
                sample_y <= q.sy;
                cell_col <= q.col;
                cell_row <= q.row;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall; one long hold-off once the run is under way so that the
    // output register fills and the block pushes back on its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && n_req >= 120)
        begin
            hold_cnt  <= 400;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (idle_mode == 0)
            out_stall <= ($urandom_range(99) < 87);
        else if (idle_mode == 1)
            out_stall <= ($urandom_range(99) < 24);
        else
            out_stall <= 1'b0;
    end

    // monitor: update the predictor on accepted requests, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            kde_res_t want;
            bit moved;
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                n_dens++;
                if (density_fifo.size() == 0)
                begin
                    n_err++;
                    $display("%0t: unexpected density %h sat %b full %b",
                             $time, density, saturated, store_full);
                end
                else
                begin
                    want = density_fifo.pop_front();
                    if (density !== want.dens)
                    begin
                        n_err++;
                        $display("%0t: density expected %h actual %h",
                                 $time, want.dens, density);
                    end
                    if (saturated !== want.sat)
                    begin
                        n_err++;
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.sat, saturated);
                    end
                    if (store_full !== want.full)
                    begin
                        n_err++;
                        $display("%0t: store_full expected %b actual %b",
                                 $time, want.full, store_full);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                n_req++;
                case (opcode_t'(opcode))
                    OP_CLEAR:
                        p_count = 0;
                    OP_APPEND:
                        if (p_count < STORE_DEPTH)
                        begin
                            mem_x[p_count] = sample_x;
                            mem_y[p_count] = sample_y;
                            p_count++;
                        end
                    OP_EVAL:
                    begin
                        want = predict_density(cell_col, cell_row);
                        n_sat  += want.sat;
                        n_full += want.full;
                        density_fifo.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            // watchdog on a stuck handshake
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one register write, called at a rising edge; returns at the write edge
    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_X_ORIGIN: p_xo   = val;
            REG_X_STEP:   p_xs   = val[30:0];
            REG_Y_ORIGIN: p_yo   = val;
            REG_Y_STEP:   p_ys   = val[30:0];
            REG_KX:       p_kx   = val;
            REG_KY:       p_ky   = val;
            REG_NORM:     p_norm = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [31:0] xo, input logic [31:0] xs,
                             input logic [31:0] yo, input logic [31:0] ys,
                             input logic [31:0] kx, input logic [31:0] ky,
                             input logic [31:0] nrm);
        @(posedge clk);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_Y_STEP, ys);
        write_reg(REG_KX, kx);
        write_reg(REG_KY, ky);
        write_reg(REG_NORM, nrm);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sender pause: every request taken, every density back, then the
    // evaluate pipeline given time to go quiet
    task automatic drain();
        while (req_fifo.size() > 0 || in_valid || density_fifo.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic push_req(input opcode_t op, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [9:0] col,
                            input logic [9:0] row);
        kde_req_t q;
        q.op  = op;
        q.sx  = sx;
        q.sy  = sy;
        q.col = col;
        q.row = row;
        req_fifo.push_back(q);
    endtask

    // sample placed near the first few cells of the current grid
    function automatic logic [31:0] near_coord(input logic [31:0] origin,
                                               input logic [30:0] step);
        logic [63:0] span;
        span = 64'(step) * 64'd12 + 64'h40000;
        return origin + 32'($urandom_range(0, 32'(span > 64'hFFFF_FFFF ?
                                       64'hFFFF_FFFF : span)));
    endfunction

    // well-formed clear/append/evaluate sequences with random content,
    // mixed with raw noise requests
    task automatic random_traffic(input int n);
        int made;
        int m;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_req(opcode_t'($urandom_range(3)), $urandom, $urandom,
                         10'($urandom), 10'($urandom));
                made++;
            end
            else
            begin
                if ($urandom_range(3) != 0)
                begin
                    push_req(OP_CLEAR, $urandom, $urandom, 10'($urandom), 10'($urandom));
                    made++;
                end
                m = ($urandom_range(15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
                repeat (m)
                begin
                    if ($urandom_range(4) != 0)
                        push_req(OP_APPEND, near_coord(p_xo, p_xs), near_coord(p_yo, p_ys),
                                 10'($urandom), 10'($urandom));
                    else
                        push_req(OP_APPEND, $urandom, $urandom, 10'($urandom), 10'($urandom));
                    made++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(6) != 0)
                        push_req(OP_EVAL, $urandom, $urandom,
                                 10'($urandom_range(15)), 10'($urandom_range(15)));
                    else
                        push_req(OP_EVAL, $urandom, $urandom, 10'($urandom), 10'($urandom));
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_ORIGIN;
        cfg_data  = '0;
        idle_mode = 0;
        n_req = 0; n_dens = 0; n_sat = 0; n_full = 0; n_err = 0;
        quiet_cycles = 0;
        p_count = 0;
        build_exp_lut();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners at the reset register values
        load_regs(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h8000, 32'h8000, 32'd10430);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd0, 10'd0);             // empty store
        push_req(OP_NONE, 32'hFFFF_FFFF, 32'h0, 10'h3FF, 10'h3FF); // ignored code
        push_req(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 10'd0, 10'd0);
        push_req(OP_APPEND, 32'h0000_8000, 32'h0000_8000, 10'd0, 10'd0);
        push_req(OP_APPEND, 32'h0001_8000, 32'h0000_8000, 10'd0, 10'd0);
        push_req(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 10'd0, 10'd0);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd0, 10'd0);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd1, 10'd0);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'h3FF, 10'h3FF);         // far corner
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd0, 10'h3FF);
        push_req(OP_CLEAR, 32'h0, 32'h0, 10'd0, 10'd0);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd3, 10'd3);             // cleared store
        push_req(OP_APPEND, 32'h0003_8000, 32'h0003_8000, 10'd0, 10'd0);
        push_req(OP_APPEND, 32'h0003_0000, 32'h0004_0000, 10'd0, 10'd0);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd3, 10'd3);
        push_req(OP_EVAL, 32'h0, 32'h0, 10'd7, 10'd2);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_mode = ph / 2;
            case (ph)
                0: load_regs(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h8000, 32'h8000, 32'd10430);
                1: load_regs(32'hFFF8_0000, 32'h8000, 32'hFFFC_0000, 32'hC000,
                             32'h10000, 32'h4000, 32'd20000);
                2: load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                             32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
                3: load_regs(32'h0001_0000, 32'h1, 32'h0, 32'h10000, 32'h0, 32'h0,
                             32'hFFFF_FFFF);
                4: load_regs($urandom, $urandom_range(32'h7FFF_FFFF) >> $urandom_range(15),
                             $urandom, $urandom_range(32'h7FFF_FFFF) >> $urandom_range(15),
                             $urandom >> $urandom_range(20), $urandom >> $urandom_range(20),
                             $urandom >> $urandom_range(16));
                default: load_regs(32'hFFFF_0000, 32'h10000, 32'h0, 32'h8000,
                                   32'h8000, 32'h10000, 32'h10000);
            endcase
            random_traffic(95);
            drain();
        end

        $display("covered %0d requests, %0d densities (%0d saturated, %0d with store full)",
                 n_req, n_dens, n_sat, n_full);
        $display("register settings: reset, offset, extremes, zero bandwidth, random");
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
sv/gkde_pkg.sv
sv/gkde_sample_mem.sv
sv/gkde_axis.sv
sv/gkde_kernel.sv
sv/gaussian_kde_grid_eval_core.sv
sim/tb_top.sv
